@@ rtl/ssi_pkg.sv @@
`timescale 1ns / 1ps
package ssi_pkg;

	localparam int KW = 32;

	typedef struct packed {
		logic straddle;
		logic neg;
	} ssi_ctl_t;

endpackage

@@ rtl/ssi_front.sv @@
`timescale 1ns / 1ps
module ssi_front #(
	parameter int CW = 16,
	parameter int MW = 2 * CW + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by,
	input  logic signed [CW-1:0] ox,
	input  logic signed [CW-1:0] oy,
	input  logic signed [CW-1:0] px,
	input  logic signed [CW-1:0] py,
	output logic                 vld_s3,
	output ssi_pkg::ssi_ctl_t    ctl_s3,
	output logic [MW-1:0]        nmag_s3,
	output logic [MW-1:0]        dmag_s3
);

	localparam int DW = CW + 1;
	localparam int PW = 2 * CW + 2;
	localparam int XW = 2 * CW + 3;

	logic              vld_s1, vld_s2;
	logic signed [DW-1:0] abx_s1, aby_s1, opx_s1, opy_s1;
	logic signed [DW-1:0] aox_s1, aoy_s1, apx_s1, apy_s1;
	logic signed [PW-1:0] cp1_s2, cp2_s2, co1_s2, co2_s2;
	logic signed [PW-1:0] n1_s2, n2_s2, d1_s2, d2_s2;
	logic signed [XW-1:0] c_p, c_o, num, den;
	logic signed [XW-1:0] num_abs, den_abs;
	ssi_pkg::ssi_ctl_t    ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			abx_s1 <= DW'(bx) - DW'(ax);
			aby_s1 <= DW'(by) - DW'(ay);
			opx_s1 <= DW'(px) - DW'(ox);
			opy_s1 <= DW'(py) - DW'(oy);
			aox_s1 <= DW'(ox) - DW'(ax);
			aoy_s1 <= DW'(oy) - DW'(ay);
			apx_s1 <= DW'(px) - DW'(ax);
			apy_s1 <= DW'(py) - DW'(ay);
			cp1_s2 <= PW'(abx_s1) * PW'(apy_s1);
			cp2_s2 <= PW'(aby_s1) * PW'(apx_s1);
			co1_s2 <= PW'(abx_s1) * PW'(aoy_s1);
			co2_s2 <= PW'(aby_s1) * PW'(aox_s1);
			n1_s2  <= PW'(aox_s1) * PW'(opy_s1);
			n2_s2  <= PW'(aoy_s1) * PW'(opx_s1);
			d1_s2  <= PW'(abx_s1) * PW'(opy_s1);
			d2_s2  <= PW'(aby_s1) * PW'(opx_s1);
			ctl_s3  <= ctl;
			nmag_s3 <= MW'(num_abs);
			dmag_s3 <= MW'(den_abs);
		end
	end

	always_comb begin
		c_p = XW'(cp1_s2) - XW'(cp2_s2);
		c_o = XW'(co1_s2) - XW'(co2_s2);
		num = XW'(n1_s2) - XW'(n2_s2);
		den = XW'(d1_s2) - XW'(d2_s2);
		num_abs = num[XW-1] ? -num : num;
		den_abs = den[XW-1] ? -den : den;
		ctl.straddle = ((c_p > 0) && (c_o < 0)) || ((c_p < 0) && (c_o > 0));
		ctl.neg      = num[XW-1] ^ den[XW-1];
	end

endmodule

@@ rtl/ssi_fifo.sv @@
`timescale 1ns / 1ps
module ssi_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

@@ rtl/ssi_back.sv @@
`timescale 1ns / 1ps
module ssi_back #(
	parameter int MW = 34,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  ssi_pkg::ssi_ctl_t            ctl_in,
	input  logic [MW-1:0]                nmag,
	input  logic [MW-1:0]                dmag,
	output logic                         vld_out,
	output logic                         straddle,
	output logic                         hit,
	output logic signed [ssi_pkg::KW-1:0] k_param
);

	localparam int KW = ssi_pkg::KW;
	localparam int NW = MW + FRAC_BITS + KW;
	localparam int HW = MW + FRAC_BITS;
	localparam logic [KW-1:0] ONE    = KW'(1) << FRAC_BITS;
	localparam logic [KW-1:0] K_NONE = KW'(0) - ONE;
	localparam logic [KW-1:0] K_MIN  = KW'(1) << (KW - 1);
	localparam logic [KW-1:0] K_MAX  = K_MIN - KW'(1);

	logic              vld_q [KW+1];
	ssi_pkg::ssi_ctl_t ctl_q [KW+1];
	logic              ovf_q [KW+1];
	logic [MW-1:0]     d_q   [KW+1];
	logic [MW-1:0]     r_q   [KW+1];
	logic [KW-1:0]     nlo_q [KW+1];
	logic [KW-1:0]     q_q   [KW+1];

	logic [NW-1:0] nfull;
	logic [HW-1:0] nhi;
	logic [KW-1:0] qf;
	logic          sat;
	logic [KW-1:0] kv;
	logic          hv;

	assign nfull = NW'(nmag) << (FRAC_BITS + 0);
	assign nhi   = nfull[NW-1:KW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= KW; i++) begin
				vld_q[i] <= 1'b0;
			end
			vld_out <= 1'b0;
		end else if (en) begin
			vld_q[0] <= vld_in;
			for (int i = 1; i <= KW; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
			vld_out <= vld_q[KW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_q[0] <= ctl_in;
			d_q[0]   <= dmag;
			ovf_q[0] <= nhi >= HW'(dmag);
			r_q[0]   <= nhi[MW-1:0];
			nlo_q[0] <= nfull[KW-1:0];
			q_q[0]   <= '0;
			for (int i = 1; i <= KW; i++) begin
				logic [MW:0] rs;
				logic        ge;
				rs = {r_q[i-1], nlo_q[i-1][KW-1]};
				ge = rs >= {1'b0, d_q[i-1]};
				ctl_q[i] <= ctl_q[i-1];
				d_q[i]   <= d_q[i-1];
				ovf_q[i] <= ovf_q[i-1];
				r_q[i]   <= ge ? MW'(rs - {1'b0, d_q[i-1]}) : rs[MW-1:0];
				nlo_q[i] <= nlo_q[i-1] << 1;
				q_q[i]   <= {q_q[i-1][KW-2:0], ge};
			end
			straddle <= ctl_q[KW].straddle;
			hit      <= hv;
			k_param  <= kv;
		end
	end

	always_comb begin
		qf = q_q[KW];
		if (ctl_q[KW].neg) begin
			sat = ovf_q[KW] || (qf > K_MIN);
			kv  = sat ? K_MIN : KW'(0) - qf;
			hv  = 1'b0;
		end else begin
			sat = ovf_q[KW] || qf[KW-1];
			kv  = sat ? K_MAX : qf;
			hv  = !sat && (qf != '0) && (qf < ONE);
		end
		if (!ctl_q[KW].straddle) begin
			kv = K_NONE;
			hv = 1'b0;
		end
	end

endmodule

@@ rtl/segment_segment_intersection.sv @@
`timescale 1ns / 1ps
// Segment intersection test: each beat carries segments A-B and O-P; the block reports whether O
// and P lie strictly on opposite sides of line AB and, if so, the parameter k along AB in signed
// fixed point with FRAC_BITS fraction bits, truncated toward zero and saturated to 32 bits, with
// hit set for 0 < k < 1. One beat is taken every clock while in_stall is low; each result passes
// through a three-stage cross-product front, a four-entry queue and a 32-step pipelined restoring
// divider.
module segment_segment_intersection #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] ox,
	input  logic signed [COORD_WIDTH-1:0] oy,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          straddle,
	output logic                          hit,
	output logic signed [ssi_pkg::KW-1:0] k_param
);

	localparam int MW = 2 * COORD_WIDTH + 2;
	localparam int EW = MW + MW + 2;

	logic              front_en, back_en;
	logic              vld_s3;
	ssi_pkg::ssi_ctl_t ctl_s3, ctl_pop;
	logic [MW-1:0]     nmag_s3, dmag_s3, nmag_pop, dmag_pop;
	logic [EW-1:0]     fifo_rdata;
	logic              full, empty, push, pop;

	assign push     = vld_s3 && !full;
	assign front_en = !vld_s3 || !full;
	assign in_stall = !front_en;
	assign back_en  = !(out_valid && out_stall);
	assign pop      = back_en && !empty;
	assign {ctl_pop, nmag_pop, dmag_pop} = fifo_rdata;

	ssi_front #(.CW(COORD_WIDTH), .MW(MW)) u_front (
		.clk, .arst_n, .en(front_en), .vld_in(in_valid),
		.ax, .ay, .bx, .by, .ox, .oy, .px, .py,
		.vld_s3, .ctl_s3, .nmag_s3, .dmag_s3
	);

	ssi_fifo #(.W(EW)) u_fifo (
		.clk, .arst_n, .push, .wdata({ctl_s3, nmag_s3, dmag_s3}),
		.pop, .rdata(fifo_rdata), .full, .empty
	);

	ssi_back #(.MW(MW), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .en(back_en), .vld_in(pop), .ctl_in(ctl_pop),
		.nmag(nmag_pop), .dmag(dmag_pop), .vld_out(out_valid),
		.straddle, .hit, .k_param
	);

endmodule

@@ rtl/ssi_checker.sv @@
`timescale 1ns / 1ps
module ssi_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          straddle,
	input logic                          hit,
	input logic signed [ssi_pkg::KW-1:0] k_param
);

	localparam logic signed [ssi_pkg::KW-1:0] ONE = ssi_pkg::KW'(1) << FRAC_BITS;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(k_param) && $stable(hit)
			&& $stable(straddle))
		else $error("stalled result changed");

	a_hit_straddle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> straddle)
		else $error("hit without straddle");

	a_none_k: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !straddle |-> k_param == -ONE)
		else $error("bad parameter without straddle");

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (k_param > 0) && (k_param < ONE))
		else $error("hit with parameter out of range");

endmodule

bind segment_segment_intersection ssi_checker #(.FRAC_BITS(FRAC_BITS)) u_ssi_checker (
	.clk, .arst_n, .out_valid, .out_stall, .straddle, .hit, .k_param
);
